@@ hdl/pva_pkg.sv @@
package pva_pkg;

  localparam int VOICES     = 32;
  localparam int AGE_BITS   = 32;
  localparam int PRIO_W     = 8;
  localparam int SESS_W     = 32;
  localparam int TYPE_W     = 2;
  localparam int REQ_VIDX_W = 5;
  localparam int OUT_VIDX_W = 5;
  localparam int OUT_CNT_W  = 6;
  localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W      = $clog2(VOICES + 1);

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CANCEL  = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [SESS_W-1:0]   sess;
    logic [AGE_BITS-1:0] age;
  } voice_ent_t;

  localparam int ENT_W = $bits(voice_ent_t);

endpackage

@@ hdl/pva_ram.sv @@
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/pva_cmp.sv @@
module pva_cmp import pva_pkg::*; (
  input  voice_ent_t        cand,
  input  voice_ent_t        best,
  input  logic [PRIO_W-1:0] req_prio,
  output logic              better
);

  logic cand_prot;
  logic best_prot;

  assign cand_prot = cand.prio > req_prio;
  assign best_prot = best.prio > req_prio;

  always_comb begin
    if (cand_prot != best_prot) begin
      better = !cand_prot;
    end else if (cand.prio != best.prio) begin
      better = cand.prio < best.prio;
    end else begin
      better = cand.age < best.age;
    end
  end

endmodule

@@ hdl/priority_voice_allocator.sv @@
// Voice allocator with priority-based stealing. An item is accepted when start is high
// and busy is low. Allocate and cancel items sweep the voice table one entry per cycle
// through a table RAM with one write and one read port and one shared victim comparator,
// then pass to the finish state; release and unknown items go straight to it from idle.
// Each result is shown for exactly one cycle with out_valid high; the receiver cannot
// stall it, and a new item may be started in the same cycle the result is shown.
module priority_voice_allocator import pva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [TYPE_W-1:0]     in_req_type,
  input  logic [PRIO_W-1:0]     in_req_priority,
  input  logic [SESS_W-1:0]     in_req_session,
  input  logic [REQ_VIDX_W-1:0] in_req_voice,
  output logic                  out_valid,
  output logic [OUT_VIDX_W-1:0] out_voice_index,
  output logic                  out_stole,
  output logic [SESS_W-1:0]     out_stolen_session,
  output logic [OUT_CNT_W-1:0]  out_freed_count,
  output logic [OUT_CNT_W-1:0]  out_active_count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                state_r;
  req_type_t             req_type_r;
  logic [PRIO_W-1:0]     req_prio_r;
  logic [SESS_W-1:0]     req_sess_r;
  logic [VIDX_W-1:0]     rel_idx_r;
  logic                  rel_ok_r;
  logic [VOICES-1:0]     active_r;
  logic [CNT_W-1:0]      active_cnt_r;
  logic [AGE_BITS-1:0]   age_r;
  logic [CNT_W-1:0]      rd_idx_r;
  logic                  dv_r;
  logic [VIDX_W-1:0]     idx_d_r;
  logic                  free_found_r;
  logic [VIDX_W-1:0]     free_idx_r;
  logic [VIDX_W-1:0]     best_idx_r;
  voice_ent_t            best_r;
  logic [CNT_W-1:0]      freed_r;
  logic                  out_valid_r;
  logic [OUT_VIDX_W-1:0] out_voice_index_r;
  logic                  out_stole_r;
  logic [SESS_W-1:0]     out_stolen_session_r;
  logic [OUT_CNT_W-1:0]  out_freed_count_r;
  logic [OUT_CNT_W-1:0]  out_active_count_r;

  logic [VIDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]      ram_rd;
  voice_ent_t            rd_ent;
  voice_ent_t            wr_ent;
  logic                  wr_en;
  logic [VIDX_W-1:0]     pick;
  logic                  better;
  logic                  rel_hit;
  logic [CNT_W-1:0]      freed_new;
  logic [CNT_W-1:0]      cnt_new;

  assign busy    = state_r != ST_IDLE;
  assign rd_addr = rd_idx_r[VIDX_W-1:0];
  assign rd_ent  = voice_ent_t'(ram_rd);
  assign pick    = free_found_r ? free_idx_r : best_idx_r;
  assign wr_en   = (state_r == ST_FINISH) && (req_type_r == REQ_ALLOC);
  assign wr_ent  = '{prio: req_prio_r, sess: req_sess_r, age: age_r};
  assign rel_hit = rel_ok_r && active_r[rel_idx_r];

  pva_ram #(
    .WIDTH (ENT_W),
    .DEPTH (VOICES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pick),
    .wr_data (wr_ent),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  pva_cmp u_cmp (
    .cand     (rd_ent),
    .best     (best_r),
    .req_prio (req_prio_r),
    .better   (better)
  );

  always_comb begin
    freed_new = '0;
    cnt_new   = active_cnt_r;
    case (req_type_r)
      REQ_ALLOC: begin
        cnt_new = active_cnt_r + CNT_W'(free_found_r);
      end
      REQ_RELEASE: begin
        freed_new = CNT_W'(rel_hit);
        cnt_new   = active_cnt_r - CNT_W'(rel_hit);
      end
      REQ_CANCEL: begin
        freed_new = freed_r;
        cnt_new   = active_cnt_r - freed_r;
      end
      default: begin
        freed_new = '0;
        cnt_new   = active_cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= '0;
      active_cnt_r <= '0;
      age_r        <= '0;
      dv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_type_r   <= req_type_t'(in_req_type);
            req_prio_r   <= in_req_priority;
            req_sess_r   <= in_req_session;
            rel_idx_r    <= VIDX_W'(in_req_voice);
            rel_ok_r     <= 32'(in_req_voice) < VOICES;
            rd_idx_r     <= '0;
            free_found_r <= 1'b0;
            freed_r      <= '0;
            if (in_req_type == REQ_ALLOC || in_req_type == REQ_CANCEL) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (32'(rd_idx_r) < VOICES) begin
            rd_idx_r <= rd_idx_r + CNT_W'(1);
            dv_r     <= 1'b1;
            idx_d_r  <= rd_addr;
          end
          if (dv_r) begin
            if (req_type_r == REQ_CANCEL) begin
              if (active_r[idx_d_r] && rd_ent.sess == req_sess_r) begin
                active_r[idx_d_r] <= 1'b0;
                freed_r           <= freed_r + CNT_W'(1);
              end
            end else begin
              if (!active_r[idx_d_r] && !free_found_r) begin
                free_found_r <= 1'b1;
                free_idx_r   <= idx_d_r;
              end
              if (idx_d_r == '0 || better) begin
                best_idx_r <= idx_d_r;
                best_r     <= rd_ent;
              end
            end
            if (32'(idx_d_r) == VOICES - 1) begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          state_r              <= ST_IDLE;
          out_valid_r          <= 1'b1;
          out_voice_index_r    <= '0;
          out_stole_r          <= 1'b0;
          out_stolen_session_r <= '0;
          out_freed_count_r    <= OUT_CNT_W'(freed_new);
          out_active_count_r   <= OUT_CNT_W'(cnt_new);
          active_cnt_r         <= cnt_new;
          case (req_type_r)
            REQ_ALLOC: begin
              active_r[pick]    <= 1'b1;
              age_r             <= age_r + AGE_BITS'(1);
              out_voice_index_r <= OUT_VIDX_W'(pick);
              out_stole_r       <= !free_found_r;
              if (!free_found_r) begin
                out_stolen_session_r <= best_r.sess;
              end
            end
            REQ_RELEASE: begin
              if (rel_hit) begin
                active_r[rel_idx_r] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_voice_index    = out_voice_index_r;
  assign out_stole          = out_stole_r;
  assign out_stolen_session = out_stolen_session_r;
  assign out_freed_count    = out_freed_count_r;
  assign out_active_count   = out_active_count_r;

`ifndef SYNTHESIS
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (32'(active_cnt_r) == $countones(active_r)))
    else $error("active count out of step with active bits");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_steal_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stole) |-> (32'(out_active_count) == VOICES))
    else $error("steal reported while a voice was free");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result shown while still working");
`endif

endmodule

@@ bench/pva_checker.sv @@
`timescale 1ns / 1ps

module pva_checker import pva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [TYPE_W-1:0]     in_req_type,
  input  logic [PRIO_W-1:0]     in_req_priority,
  input  logic [SESS_W-1:0]     in_req_session,
  input  logic [REQ_VIDX_W-1:0] in_req_voice,
  input  logic                  out_valid,
  input  logic [OUT_VIDX_W-1:0] out_voice_index,
  input  logic                  out_stole,
  input  logic [SESS_W-1:0]     out_stolen_session,
  input  logic [OUT_CNT_W-1:0]  out_freed_count,
  input  logic [OUT_CNT_W-1:0]  out_active_count,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_checked,
  output int                    steals_seen,
  output int                    widest_cancel
);

  typedef struct {
    logic [OUT_VIDX_W-1:0] voice_index;
    logic                  stole;
    logic [SESS_W-1:0]     stolen_session;
    logic [OUT_CNT_W-1:0]  freed_count;
    logic [OUT_CNT_W-1:0]  active_count;
  } voice_outcome_t;

  logic                voice_on[VOICES];
  logic [PRIO_W-1:0]   voice_prio[VOICES];
  logic [SESS_W-1:0]   voice_sess[VOICES];
  logic [AGE_BITS-1:0] voice_stamp[VOICES];
  logic [AGE_BITS-1:0] next_stamp;

  voice_outcome_t pending_outcomes[$];
  int mismatch_count = 0;
  int checked_count = 0;
  int steal_count = 0;
  int cancel_peak = 0;

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s (result %0d): got %0h, expected %0h",
             $time, field, checked_count, got, want);
  endtask

  // true when voice a makes a better steal victim than voice b
  function automatic logic outranks(input int a, input int b, input logic [PRIO_W-1:0] pr);
    logic a_guarded;
    logic b_guarded;
    a_guarded = voice_prio[a] > pr;
    b_guarded = voice_prio[b] > pr;
    if (a_guarded != b_guarded) return !a_guarded;
    if (voice_prio[a] != voice_prio[b]) return voice_prio[a] < voice_prio[b];
    return voice_stamp[a] < voice_stamp[b];
  endfunction

  function automatic voice_outcome_t serve_request(input req_type_t kind,
                                                   input logic [PRIO_W-1:0] pr,
                                                   input logic [SESS_W-1:0] se,
                                                   input logic [REQ_VIDX_W-1:0] vo);
    voice_outcome_t res;
    int pick;
    int live;
    res.voice_index = '0;
    res.stole = 1'b0;
    res.stolen_session = '0;
    res.freed_count = '0;
    res.active_count = '0;
    case (kind)
      REQ_ALLOC: begin
        pick = -1;
        for (int i = 0; i < VOICES; i++)
          if (!voice_on[i] && pick < 0) pick = i;
        if (pick < 0) begin
          pick = 0;
          for (int i = 1; i < VOICES; i++)
            if (outranks(i, pick, pr)) pick = i;
          res.stole = 1'b1;
          res.stolen_session = voice_sess[pick];
        end
        voice_prio[pick] = pr;
        voice_sess[pick] = se;
        voice_stamp[pick] = next_stamp;
        next_stamp = next_stamp + AGE_BITS'(1);
        voice_on[pick] = 1'b1;
        res.voice_index = pick[OUT_VIDX_W-1:0];
      end
      REQ_RELEASE: begin
        if (int'(vo) < VOICES && voice_on[vo]) begin
          voice_on[vo] = 1'b0;
          res.freed_count = OUT_CNT_W'(1);
        end
      end
      REQ_CANCEL: begin
        for (int i = 0; i < VOICES; i++) begin
          if (voice_on[i] && voice_sess[i] == se) begin
            voice_on[i] = 1'b0;
            res.freed_count = res.freed_count + OUT_CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
    live = 0;
    for (int i = 0; i < VOICES; i++)
      if (voice_on[i]) live++;
    res.active_count = live[OUT_CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    voice_outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) voice_on[i] = 1'b0;
      next_stamp = '0;
      pending_outcomes.delete();
    end else begin
      if (out_valid) begin
        if (pending_outcomes.size() == 0) begin
          flag_mismatch("result with no item outstanding", 32'(out_voice_index), 32'(0));
        end else begin
          want = pending_outcomes.pop_front();
          checked_count++;
          if (want.stole) steal_count++;
          if (out_voice_index !== want.voice_index)
            flag_mismatch("voice_index", 32'(out_voice_index), 32'(want.voice_index));
          if (out_stole !== want.stole)
            flag_mismatch("stole", 32'(out_stole), 32'(want.stole));
          if (out_stolen_session !== want.stolen_session)
            flag_mismatch("stolen_session", out_stolen_session, want.stolen_session);
          if (out_freed_count !== want.freed_count)
            flag_mismatch("freed_count", 32'(out_freed_count), 32'(want.freed_count));
          if (out_active_count !== want.active_count)
            flag_mismatch("active_count", 32'(out_active_count), 32'(want.active_count));
        end
      end
      if (start && !busy) begin
        want = serve_request(req_type_t'(in_req_type), in_req_priority, in_req_session,
                             in_req_voice);
        pending_outcomes.push_back(want);
        if (in_req_type == REQ_CANCEL && int'(want.freed_count) > cancel_peak)
          cancel_peak = int'(want.freed_count);
      end
    end
    mismatches <= mismatch_count;
    outstanding <= pending_outcomes.size();
    results_checked <= checked_count;
    steals_seen <= steal_count;
    widest_cancel <= cancel_peak;
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pva_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 600;
  localparam int DRAIN_CYCLES = 50;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [TYPE_W-1:0]     in_req_type = REQ_NONE;
  logic [PRIO_W-1:0]     in_req_priority = '0;
  logic [SESS_W-1:0]     in_req_session = '0;
  logic [REQ_VIDX_W-1:0] in_req_voice = '0;
  logic                  out_valid;
  logic [OUT_VIDX_W-1:0] out_voice_index;
  logic                  out_stole;
  logic [SESS_W-1:0]     out_stolen_session;
  logic [OUT_CNT_W-1:0]  out_freed_count;
  logic [OUT_CNT_W-1:0]  out_active_count;

  int mismatches;
  int outstanding;
  int results_checked;
  int steals_seen;
  int widest_cancel;

  int gap_pct = 0;
  int stall_cycles = 0;
  int requests_sent = 0;
  int allocs_sent = 0;
  int releases_sent = 0;
  int cancels_sent = 0;
  int ignored_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  priority_voice_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_req_priority    (in_req_priority),
    .in_req_session     (in_req_session),
    .in_req_voice       (in_req_voice),
    .out_valid          (out_valid),
    .out_voice_index    (out_voice_index),
    .out_stole          (out_stole),
    .out_stolen_session (out_stolen_session),
    .out_freed_count    (out_freed_count),
    .out_active_count   (out_active_count)
  );

  pva_checker check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_req_priority    (in_req_priority),
    .in_req_session     (in_req_session),
    .in_req_voice       (in_req_voice),
    .out_valid          (out_valid),
    .out_voice_index    (out_voice_index),
    .out_stole          (out_stole),
    .out_stolen_session (out_stolen_session),
    .out_freed_count    (out_freed_count),
    .out_active_count   (out_active_count),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .results_checked    (results_checked),
    .steals_seen        (steals_seen),
    .widest_cancel      (widest_cancel)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue(input req_type_t kind, input logic [PRIO_W-1:0] pr,
                       input logic [SESS_W-1:0] se, input logic [REQ_VIDX_W-1:0] vo);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= kind;
    in_req_priority <= pr;
    in_req_session <= se;
    in_req_voice <= vo;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (kind)
      REQ_ALLOC:   allocs_sent++;
      REQ_RELEASE: releases_sent++;
      REQ_CANCEL:  cancels_sent++;
      default:     ignored_sent++;
    endcase
    if (kind != REQ_NONE) requests_sent++;
  endtask

  // corner priorities half the time so that ties and age ordering come up
  function automatic logic [PRIO_W-1:0] pick_prio();
    logic [PRIO_W-1:0] corners[6];
    corners = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
    if ($urandom_range(1) == 0) return corners[$urandom_range(5)];
    return PRIO_W'($urandom_range(255));
  endfunction

  function automatic logic [SESS_W-1:0] pick_session();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic mixed_episode();
    logic [SESS_W-1:0] pool[4];
    logic [SESS_W-1:0] se;
    int len;
    int roll;
    foreach (pool[i]) pool[i] = pick_session();
    len = $urandom_range(20, 80);
    repeat (len) begin
      roll = $urandom_range(99);
      se = ($urandom_range(7) == 0) ? $urandom : pool[$urandom_range(3)];
      if (roll < 62)
        issue(REQ_ALLOC, pick_prio(), se, REQ_VIDX_W'($urandom_range(31)));
      else if (roll < 78)
        issue(REQ_RELEASE, PRIO_W'($urandom_range(255)), $urandom,
              REQ_VIDX_W'($urandom_range(31)));
      else if (roll < 95)
        issue(REQ_CANCEL, PRIO_W'($urandom_range(255)), se,
              REQ_VIDX_W'($urandom_range(31)));
      else
        issue(REQ_NONE, PRIO_W'($urandom_range(255)), $urandom,
              REQ_VIDX_W'($urandom_range(31)));
    end
  endtask

  // allocate at least a table's worth of voices to one session, stealing as needed, then cancel it
  task automatic flood_episode();
    logic [SESS_W-1:0] se;
    logic top_prio;
    int len;
    se = pick_session();
    top_prio = 1'($urandom_range(1));
    len = $urandom_range(VOICES, VOICES + 8);
    repeat (len)
      issue(REQ_ALLOC, top_prio ? 8'hff : pick_prio(), se, REQ_VIDX_W'($urandom_range(31)));
    issue(REQ_CANCEL, PRIO_W'($urandom_range(255)), se, REQ_VIDX_W'($urandom_range(31)));
  endtask

  initial begin
    int pace[3];
    int target;
    pace = '{14, 74, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 0;
    issue(REQ_ALLOC,   8'hff, 32'hffff_ffff, 5'd0);
    issue(REQ_ALLOC,   8'h00, 32'h0000_0000, 5'd31);
    issue(REQ_ALLOC,   8'h80, 32'h5a5a_a5a5, 5'd0);
    issue(REQ_RELEASE, 8'hff, 32'hffff_ffff, 5'd1);
    issue(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd1);
    issue(REQ_RELEASE, 8'h7f, 32'h0000_0000, 5'd31);
    issue(REQ_NONE,    8'hff, 32'hffff_ffff, 5'd31);
    issue(REQ_ALLOC,   8'h01, 32'h0000_0000, 5'd0);
    issue(REQ_CANCEL,  8'h00, 32'hffff_ffff, 5'd0);
    issue(REQ_CANCEL,  8'hff, 32'h0000_0001, 5'd31);
    issue(REQ_CANCEL,  8'h00, 32'h0000_0000, 5'd0);
    issue(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd2);
    issue(REQ_CANCEL,  8'h00, 32'h5a5a_a5a5, 5'd0);
    issue(REQ_RELEASE, 8'h00, 32'h0000_0000, 5'd0);

    foreach (pace[p]) begin
      gap_pct = pace[p];
      target = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) begin
        if ($urandom_range(4) == 0) flood_episode();
        else mixed_episode();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d allocate, %0d release, %0d cancel and %0d ignored items",
             allocs_sent, releases_sent, cancels_sent, ignored_sent);
    $display("Checked %0d results: %0d steals, largest cancel freed %0d voices",
             results_checked, steals_seen, widest_cancel);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pva_pkg.sv
hdl/pva_ram.sv
hdl/pva_cmp.sv
hdl/priority_voice_allocator.sv
bench/pva_checker.sv
bench/testbench.sv
